// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants of the round-robin thread scheduler.
// Used by rrts_ctrl, rrts_dp and round_robin_thread_scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

	// Slot state codes
	typedef enum logic [1:0] {
		ST_DEAD     = 2'd0,
		ST_RUNNABLE = 2'd1,
		ST_RUNNING  = 2'd2,
		ST_BLOCKED  = 2'd3
	} slot_st_t;

	// Operation codes of an input word
	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_EXIT   = 2'd1,
		OP_JOIN   = 2'd2,
		OP_YIELD  = 2'd3
	} op_t;

	localparam int OP_W   = 2;
	localparam int SLOT_W = 3;

	// Access pointer moves
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_CUR,
		PTR_TGT,
		PTR_NEXT
	} ptr_sel_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_CR_SCAN,
		S_EX_KILL,
		S_EX_WAKE,
		S_JN_RANGE,
		S_JN_CHECK,
		S_JN_BLOCK,
		S_PK_DEMOTE,
		S_PK_SCAN,
		S_PK_SET,
		S_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     take;
		ptr_sel_t ptr_sel;
		logic     cnt_clr;
		logic     st_we;
		slot_st_t st_wdata;
		logic     wait_set;
		logic     wait_clr;
		logic     cur_load;
		logic     res_new;
		logic     res_fail;
		logic     out_push;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		slot_st_t rd_st;
		logic     wake_hit;
		logic     ptr_last;
		logic     cnt_last;
		logic     tgt_oob;
		logic     out_free;
	} stat_t;

endpackage

// ===== hw/rtl/rrts_ctrl.sv =====
// Sequencer of the thread scheduler: walks create, exit, join and yield
// through single-slot accesses. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [rrts_pkg::OP_W-1:0] op,
	input  rrts_pkg::stat_t          stat,
	output rrts_pkg::cmd_t           cmd
);
	import rrts_pkg::*;

	state_t state_q;
	state_t state_nxt;
	op_t    op_in;

	assign op_in    = op_t'(op);
	assign in_ready = (state_q == S_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (op_in)
						OP_CREATE: state_nxt = S_CR_SCAN;
						OP_EXIT:   state_nxt = S_EX_KILL;
						OP_JOIN:   state_nxt = S_JN_RANGE;
						OP_YIELD:  state_nxt = S_PK_DEMOTE;
						default:   state_nxt = S_IDLE;
					endcase
				end
			end
			S_CR_SCAN: begin
				if (stat.rd_st == ST_DEAD || stat.ptr_last) begin
					state_nxt = S_FINISH;
				end
			end
			S_EX_KILL: state_nxt = S_EX_WAKE;
			S_EX_WAKE: begin
				if (stat.ptr_last) begin
					state_nxt = S_PK_DEMOTE;
				end
			end
			S_JN_RANGE: state_nxt = stat.tgt_oob ? S_FINISH : S_JN_CHECK;
			S_JN_CHECK: state_nxt = (stat.rd_st == ST_DEAD) ? S_FINISH : S_JN_BLOCK;
			S_JN_BLOCK: state_nxt = S_PK_DEMOTE;
			S_PK_DEMOTE: state_nxt = S_PK_SCAN;
			S_PK_SCAN: begin
				if (stat.rd_st == ST_RUNNABLE || stat.cnt_last) begin
					state_nxt = S_PK_SET;
				end
			end
			S_PK_SET: state_nxt = S_FINISH;
			S_FINISH: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		cmd.ptr_sel  = PTR_HOLD;
		cmd.st_wdata = ST_DEAD;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					unique case (op_in)
						OP_CREATE: cmd.ptr_sel = PTR_ZERO;
						OP_EXIT:   cmd.ptr_sel = PTR_CUR;
						OP_JOIN:   cmd.ptr_sel = PTR_HOLD;
						OP_YIELD:  cmd.ptr_sel = PTR_CUR;
						default:   cmd.ptr_sel = PTR_HOLD;
					endcase
				end
			end
			// claim the lowest dead slot or report a full table
			S_CR_SCAN: begin
				if (stat.rd_st == ST_DEAD) begin
					cmd.st_we    = 1'b1;
					cmd.st_wdata = ST_RUNNABLE;
					cmd.wait_clr = 1'b1;
					cmd.res_new  = 1'b1;
				end else if (stat.ptr_last) begin
					cmd.res_fail = 1'b1;
				end else begin
					cmd.ptr_sel = PTR_NEXT;
				end
			end
			S_EX_KILL: begin
				cmd.st_we    = 1'b1;
				cmd.st_wdata = ST_DEAD;
				cmd.ptr_sel  = PTR_ZERO;
			end
			// wake every slot joined on the exiting thread
			S_EX_WAKE: begin
				if (stat.wake_hit) begin
					cmd.st_we    = 1'b1;
					cmd.st_wdata = ST_RUNNABLE;
					cmd.wait_clr = 1'b1;
				end
				cmd.ptr_sel = stat.ptr_last ? PTR_CUR : PTR_NEXT;
			end
			S_JN_RANGE: begin
				if (!stat.tgt_oob) begin
					cmd.ptr_sel = PTR_TGT;
				end
			end
			S_JN_CHECK: begin
				if (stat.rd_st != ST_DEAD) begin
					cmd.ptr_sel = PTR_CUR;
				end
			end
			S_JN_BLOCK: begin
				cmd.st_we    = 1'b1;
				cmd.st_wdata = ST_BLOCKED;
				cmd.wait_set = 1'b1;
			end
			// demote a running current slot, then start the scan at current+1
			S_PK_DEMOTE: begin
				if (stat.rd_st == ST_RUNNING) begin
					cmd.st_we    = 1'b1;
					cmd.st_wdata = ST_RUNNABLE;
				end
				cmd.ptr_sel = PTR_NEXT;
				cmd.cnt_clr = 1'b1;
			end
			S_PK_SCAN: begin
				if (stat.rd_st == ST_RUNNABLE) begin
					cmd.cur_load = 1'b1;
				end else if (stat.cnt_last) begin
					cmd.ptr_sel = PTR_CUR;
				end else begin
					cmd.ptr_sel = PTR_NEXT;
				end
			end
			S_PK_SET: begin
				cmd.st_we    = 1'b1;
				cmd.st_wdata = ST_RUNNING;
			end
			S_FINISH: begin
				cmd.out_push = stat.out_free;
			end
			default: cmd.ptr_sel = PTR_HOLD;
		endcase
	end

endmodule

// ===== hw/rtl/rrts_dp.sv =====
// Datapath of the thread scheduler: slot table, access pointer, current
// slot and result register. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_dp #(
	parameter int THREADS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rrts_pkg::SLOT_W-1:0] target_thread,
	input  rrts_pkg::cmd_t              cmd,
	output rrts_pkg::stat_t             stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic [rrts_pkg::SLOT_W-1:0] new_thread,
	output logic [rrts_pkg::SLOT_W-1:0] running_thread
);
	import rrts_pkg::*;

	localparam int SW = $clog2(THREADS);
	localparam int EW = SW + SLOT_W;

	slot_st_t          st_q [THREADS];
	logic              wv_q [THREADS];
	logic [SLOT_W-1:0] ws_q [THREADS];

	logic [SW-1:0]     ptr_q;
	logic [SW-1:0]     cnt_q;
	logic [SW-1:0]     cur_q;
	logic [SLOT_W-1:0] tgt_q;
	logic              res_status_q;
	logic [SLOT_W-1:0] res_new_q;
	logic              out_valid_q;
	logic              status_q;
	logic [SLOT_W-1:0] new_thread_q;
	logic [SLOT_W-1:0] running_q;

	logic [EW-1:0]     tgt_ext;
	logic [EW-1:0]     ptr_ext;
	logic [EW-1:0]     cur_ext;
	logic [EW-1:0]     ws_ext;
	logic              ptr_last;
	logic [SW-1:0]     ptr_inc;

	assign tgt_ext  = {{SW{1'b0}}, tgt_q};
	assign ptr_ext  = {{SLOT_W{1'b0}}, ptr_q};
	assign cur_ext  = {{SLOT_W{1'b0}}, cur_q};
	assign ws_ext   = {{SW{1'b0}}, ws_q[ptr_q]};
	assign ptr_last = (ptr_q == SW'(THREADS - 1));
	assign ptr_inc  = ptr_last ? '0 : ptr_q + 1'b1;

	// Status toward the controller
	always_comb begin
		stat.rd_st    = st_q[ptr_q];
		stat.wake_hit = wv_q[ptr_q] && (ws_ext == cur_ext);
		stat.ptr_last = ptr_last;
		stat.cnt_last = (cnt_q == SW'(THREADS - 1));
		stat.tgt_oob  = (tgt_ext >= EW'(THREADS));
		stat.out_free = !out_valid_q || out_ready;
	end

	// Slot table: state and join wait, one entry written per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				st_q[i] <= (i == 0) ? ST_RUNNING : ST_DEAD;
				wv_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.st_we) begin
				st_q[ptr_q] <= cmd.st_wdata;
			end
			if (cmd.wait_set) begin
				wv_q[ptr_q] <= 1'b1;
			end else if (cmd.wait_clr) begin
				wv_q[ptr_q] <= 1'b0;
			end
		end
	end

	// Wait target slot, payload only
	always_ff @(posedge clk) begin
		if (cmd.wait_set) begin
			ws_q[ptr_q] <= tgt_q;
		end else if (cmd.wait_clr) begin
			ws_q[ptr_q] <= '0;
		end
	end

	// Access pointer, scan count and current slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
			cur_q <= '0;
		end else begin
			case (cmd.ptr_sel)
				PTR_ZERO: ptr_q <= '0;
				PTR_CUR:  ptr_q <= cur_q;
				PTR_TGT:  ptr_q <= tgt_ext[SW-1:0];
				PTR_NEXT: ptr_q <= ptr_inc;
				default:  ptr_q <= ptr_q;
			endcase
			if (cmd.cnt_clr) begin
				cnt_q <= SW'(1);
			end else if (cmd.ptr_sel == PTR_NEXT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.cur_load) begin
				cur_q <= ptr_q;
			end
		end
	end

	// Capture the join target and build the result
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tgt_q        <= target_thread;
			res_status_q <= 1'b0;
			res_new_q    <= '0;
		end else if (cmd.res_new) begin
			res_new_q <= ptr_ext[SLOT_W-1:0];
		end else if (cmd.res_fail) begin
			res_status_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_push) begin
			status_q     <= res_status_q;
			new_thread_q <= res_new_q;
			running_q    <= cur_ext[SLOT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign new_thread     = new_thread_q;
	assign running_thread = running_q;

endmodule

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler: sequencer plus datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   input   | in_valid / in_ready | op, target_thread
//   output  | out_valid/out_ready | status, new_thread, running_thread
//
// One word is handled at a time; each step touches one table slot.
// Create scans up from slot 0 for a dead slot; yield scans on from the current
// slot; join on a live target blocks the caller and then yields, join on a dead
// or out-of-range target just reports; exit wakes its joiners, then yields.
// Reset puts slot 0 running, all others dead; no clearing pass is needed.
// A new word is taken while the last result still waits in the output
// register; a finished result stalls only while that register is full.
`timescale 1ns / 1ps

module round_robin_thread_scheduler #(
	parameter int THREADS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rrts_pkg::OP_W-1:0]   op,
	input  logic [rrts_pkg::SLOT_W-1:0] target_thread,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic [rrts_pkg::SLOT_W-1:0] new_thread,
	output logic [rrts_pkg::SLOT_W-1:0] running_thread
);
	import rrts_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrts_dp #(
		.THREADS (THREADS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_thread  (target_thread),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.new_thread     (new_thread),
		.running_thread (running_thread)
	);

endmodule

// ===== dv/round_robin_thread_scheduler_test.sv =====
// Self-checking testbench of the round-robin thread scheduler.
// Depends on rrts_pkg and round_robin_thread_scheduler; predicts every result word.
`timescale 1ns / 1ps

module round_robin_thread_scheduler_test;
	import rrts_pkg::*;

	localparam int THREADS    = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_RANDOM   = 1080;
	localparam int DRAIN_CYC  = 3 * THREADS + 20;

	typedef struct {
		op_t              op;
		logic [SLOT_W-1:0] tgt;
		int               gap;
	} thread_cmd_t;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] new_thr;
		logic [SLOT_W-1:0] run_thr;
	} sched_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid;
	logic              in_ready;
	logic [OP_W-1:0]   op;
	logic [SLOT_W-1:0] target_thread;
	logic              out_valid;
	logic              out_ready;
	logic              status;
	logic [SLOT_W-1:0] new_thread;
	logic [SLOT_W-1:0] running_thread;

	thread_cmd_t   cmd_pending[$];
	sched_result_t sched_expected[$];
	thread_cmd_t   cmd_next;
	int            gap_left;
	int            stall_left;
	int            stall_draw;
	int            error_count;
	int            result_count;
	int            idle_cycles;

	// Scheduler image kept by the testbench
	slot_st_t          thr_state[THREADS];
	logic              thr_wait_v[THREADS];
	logic [SLOT_W-1:0] thr_wait_slot[THREADS];
	int unsigned       thr_cur;

	// Coverage tallies for the summary
	int op_seen[4];
	int full_creates;
	int dead_joins;
	int self_joins;
	int self_wakes;

	always #10 clk = ~clk;

	round_robin_thread_scheduler #(
		.THREADS(THREADS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.target_thread (target_thread),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.new_thread    (new_thread),
		.running_thread(running_thread)
	);

	// Demote the current thread, then hand the processor to the next runnable slot
	function automatic void switch_thread();
		int unsigned idx;
		logic        found;
		found = 1'b0;
		if (thr_state[thr_cur] == ST_RUNNING)
			thr_state[thr_cur] = ST_RUNNABLE;
		for (int unsigned k = 1; k < THREADS; k++) begin
			idx = (thr_cur + k) % THREADS;
			if (!found && thr_state[idx] == ST_RUNNABLE) begin
				thr_cur = idx;
				found = 1'b1;
			end
		end
		thr_state[thr_cur] = ST_RUNNING;
	endfunction

	// Apply one accepted word to the scheduler image and return its result word
	function automatic sched_result_t schedule_op(op_t o, logic [SLOT_W-1:0] tgt);
		sched_result_t res;
		int            free_slot;
		res = '0;
		free_slot = -1;
		op_seen[o]++;
		case (o)
			OP_CREATE: begin
				for (int i = THREADS - 1; i >= 0; i--)
					if (thr_state[i] == ST_DEAD)
						free_slot = i;
				if (free_slot < 0) begin
					res.status = 1'b1;
					full_creates++;
				end else begin
					thr_state[free_slot] = ST_RUNNABLE;
					thr_wait_v[free_slot] = 1'b0;
					thr_wait_slot[free_slot] = '0;
					res.new_thr = SLOT_W'(free_slot);
				end
			end
			OP_EXIT: begin
				thr_state[thr_cur] = ST_DEAD;
				for (int i = 0; i < THREADS; i++) begin
					if (thr_wait_v[i] && thr_wait_slot[i] == SLOT_W'(thr_cur)) begin
						if (i == thr_cur)
							self_wakes++;
						thr_state[i] = ST_RUNNABLE;
						thr_wait_v[i] = 1'b0;
						thr_wait_slot[i] = '0;
					end
				end
				switch_thread();
			end
			OP_JOIN: begin
				if (int'(tgt) >= THREADS || thr_state[tgt] == ST_DEAD) begin
					dead_joins++;
				end else begin
					if (int'(tgt) == thr_cur)
						self_joins++;
					thr_wait_v[thr_cur] = 1'b1;
					thr_wait_slot[thr_cur] = tgt;
					thr_state[thr_cur] = ST_BLOCKED;
					switch_thread();
				end
			end
			default: switch_thread();
		endcase
		res.run_thr = SLOT_W'(thr_cur);
		return res;
	endfunction

	// Driver: present queued words, predict each one on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_CREATE;
			target_thread <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				sched_expected.push_back(schedule_op(op_t'(op), target_thread));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (cmd_pending.size() != 0) begin
					cmd_next = cmd_pending.pop_front();
					in_valid <= 1'b1;
					op <= cmd_next.op;
					target_thread <= cmd_next.tgt;
					gap_left <= cmd_next.gap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall the output at random, check each word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				result_count++;
				if (sched_expected.size() == 0) begin
					error_count++;
					$display("%0t: result word with no prediction: status %0d new %0d running %0d",
						$time, status, new_thread, running_thread);
				end else if (sched_expected[0] != {status, new_thread, running_thread}) begin
					error_count++;
					$display("%0t: mismatch status/new/running: expected %0d/%0d/%0d, got %0d/%0d/%0d",
						$time, sched_expected[0].status, sched_expected[0].new_thr,
						sched_expected[0].run_thr, status, new_thread, running_thread);
				end
				if (sched_expected.size() != 0)
					void'(sched_expected.pop_front());
				// calm stretch every fourth block of results
				stall_draw = ((result_count / 150) % 4 == 3) ? 0 : $urandom_range(0, 18);
				stall_left <= stall_draw;
				out_ready <= (stall_draw == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic add_cmd(op_t o, logic [SLOT_W-1:0] tgt, int gap);
		thread_cmd_t c;
		c.op = o;
		c.tgt = tgt;
		c.gap = gap;
		cmd_pending.push_back(c);
	endtask

	initial begin
		int    pick;
		int    phase;
		int    gap;
		op_t   o;

		error_count = 0;
		result_count = 0;
		idle_cycles = 0;
		full_creates = 0;
		dead_joins = 0;
		self_joins = 0;
		self_wakes = 0;
		for (int i = 0; i < 4; i++)
			op_seen[i] = 0;
		for (int i = 0; i < THREADS; i++) begin
			thr_state[i] = ST_DEAD;
			thr_wait_v[i] = 1'b0;
			thr_wait_slot[i] = '0;
		end
		thr_state[0] = ST_RUNNING;
		thr_cur = 0;

		// Directed: lone thread yields, joins on dead and on itself, exits waking itself
		add_cmd(OP_YIELD, 3'd0, 0);
		add_cmd(OP_JOIN, 3'd5, 2);
		add_cmd(OP_JOIN, 3'd0, 0);
		add_cmd(OP_EXIT, 3'd0, 1);
		// fill the table, then overflow it
		for (int i = 0; i < THREADS; i++)
			add_cmd(OP_CREATE, 3'd7, i % 3);
		// round robin, joins on live slots up to the top slot, then issue THREADS exits
		add_cmd(OP_YIELD, 3'd0, 0);
		add_cmd(OP_JOIN, 3'd3, 0);
		add_cmd(OP_JOIN, 3'd7, 4);
		add_cmd(OP_JOIN, 3'd1, 0);
		add_cmd(OP_YIELD, 3'd0, 0);
		for (int i = 0; i < THREADS; i++)
			add_cmd(OP_EXIT, 3'd0, i % 2);

		// Random: phases lean toward growth, balance or teardown so that
		// both full and empty tables come up often
		for (int n = 0; n < N_RANDOM; n++) begin
			phase = (n / 60) % 3;
			pick = $urandom_range(0, 9);
			case (phase)
				0: o = (pick < 3) ? OP_CREATE : (pick < 5) ? OP_EXIT :
					(pick < 8) ? OP_JOIN : OP_YIELD;
				1: o = (pick < 6) ? OP_CREATE : (pick < 7) ? OP_EXIT :
					(pick < 9) ? OP_JOIN : OP_YIELD;
				default: o = (pick < 2) ? OP_CREATE : (pick < 5) ? OP_EXIT :
					(pick < 8) ? OP_JOIN : OP_YIELD;
			endcase
			gap = ((n / 150) % 4 == 2) ? 0 : $urandom_range(0, 18);
			add_cmd(o, SLOT_W'($urandom_range(0, THREADS - 1)), gap);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the last word to go in and every result to come back
		while (cmd_pending.size() != 0 || in_valid)
			@(negedge clk);
		while (sched_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		$display("Covered %0d creates (%0d on a full table), %0d exits (%0d self wakes),",
			op_seen[OP_CREATE], full_creates, op_seen[OP_EXIT], self_wakes);
		$display("%0d joins (%0d on dead slots, %0d on itself), %0d yields; %0d results checked",
			op_seen[OP_JOIN], dead_joins, self_joins, op_seen[OP_YIELD], result_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
